>>> rtl/core/ato_pkg.sv
// Package for the angle tracking observer.
// Holds the angle format constants, register offsets, sequencer states and
// the speed-to-turn conversion shared by the top level.
package ato_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int GAIN_FRAC_BITS = 24;
  localparam int TURN_SHIFT     = 32 - ANGLE_BITS;

  localparam int SPD_LSHIFT = (ANGLE_BITS <= 16) ? 16 - ANGLE_BITS : 0;
  localparam int SPD_RSHIFT = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;

  localparam int MUL_A_BITS = 33;
  localparam int MUL_B_BITS = 25;

  localparam logic [1:0] REG_POS_GAIN        = 2'd0;
  localparam logic [1:0] REG_VEL_GAIN        = 2'd1;
  localparam logic [1:0] REG_ANGLE_OFFSET    = 2'd2;
  localparam logic [1:0] REG_POLE_PAIR_COUNT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MULP,
    ST_MULV,
    ST_SPD,
    ST_PRED,
    ST_MULE,
    ST_OUT
  } ato_state_t;

  // Speed with 16 fractional bits of an angle LSB, as a fraction of a turn.
  function automatic logic [31:0] speed_turn(input logic signed [31:0] spd);
    logic signed [31:0] shifted;
    begin
      shifted = (spd >>> SPD_RSHIFT) <<< SPD_LSHIFT;
      return 32'(shifted);
    end
  endfunction

endpackage

>>> rtl/core/ato_mul.sv
// Shared signed multiplier of the angle tracking observer.
// Registered product; operands are selected by the top level sequencer.
module ato_mul #(
  parameter int AW = ato_pkg::MUL_A_BITS,
  parameter int BW = ato_pkg::MUL_B_BITS
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);
  import ato_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= (AW+BW)'(a) * (AW+BW)'(b);
    end
  end

endmodule

>>> rtl/core/angle_tracking_observer.sv
// Top level of the angle tracking observer: register port, sequencer,
// state and output register. Depends on ato_pkg and ato_mul.
//
// Usage: one encoder angle transaction enters on the s_ channel per control
// tick; one result transaction leaves on the m_ channel for each of them.
// Gains, angle offset and pole pairs are written over the APB-style port;
// the user must write them only while idle, the block does not enforce it; pready is always high.
// An accepted angle is worked by one shared 33 x 25 bit multiplier under a
// sequencer: position product, speed product, electrical angle and predicted
// electrical angle. The result is loaded into the output register in the
// output step, after the error, product, speed and prediction steps; only
// then does the sequencer return to idle and take the next angle.
// s_tready is high only while the sequencer waits for input; a result that
// waits on the output does not block acceptance. When the receiver stalls
// with a result pending and a new one finished, the sequencer holds the new
// result until the output register frees up.
// Reset clears the estimates, the registers (pole pairs to one) and the
// output valid flag.
module angle_tracking_observer #(
  parameter int GAIN_FRAC_BITS = ato_pkg::GAIN_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // encoder_angle[15:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // mech_angle[15:0], mech_speed[47:16], elec_angle[63:48],
  // pred_mech_angle[79:64], pred_elec_angle[95:80]
  output logic [95:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ato_pkg::*;

  localparam int AW  = MUL_A_BITS;
  localparam int BW  = MUL_B_BITS;
  localparam int PW  = AW + BW;
  localparam int VSH = GAIN_FRAC_BITS + 16 - ANGLE_BITS;
  localparam logic signed [PW-1:0] P_HALF = PW'(1) <<< (GAIN_FRAC_BITS - 1);
  localparam logic signed [PW-1:0] V_HALF = PW'(1) <<< (VSH - 1);
  localparam logic signed [PW-1:0] SPD_MAX = PW'(32'sh7fff_ffff);
  localparam logic signed [PW-1:0] SPD_MIN = -PW'(33'sh0_8000_0000);

  logic [23:0] pos_gain;
  logic [23:0] vel_gain;
  logic [15:0] angle_offset;
  logic [7:0]  pole_pair_count;

  ato_state_t state, state_next;

  logic [31:0]        enc;
  logic signed [32:0] err;
  logic [31:0]        angle_est;
  logic signed [31:0] speed_est;
  logic [31:0]        pred;
  logic [15:0]        elec;

  logic                 mul_en;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;

  logic                 out_load;
  logic [31:0]          diff;
  logic [31:0]          off_turn;
  logic signed [PW-1:0] pc_full;
  logic signed [PW-1:0] vc_full;
  logic signed [PW-1:0] spd_sum;
  logic signed [31:0]   spd_sat;
  logic                 cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_gain        <= '0;
      vel_gain        <= '0;
      angle_offset    <= '0;
      pole_pair_count <= 8'd1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_POS_GAIN:        pos_gain        <= pwdata[23:0];
        REG_VEL_GAIN:        vel_gain        <= pwdata[23:0];
        REG_ANGLE_OFFSET:    angle_offset    <= pwdata[15:0];
        REG_POLE_PAIR_COUNT: pole_pair_count <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_POS_GAIN:        prdata = {8'd0, pos_gain};
      REG_VEL_GAIN:        prdata = {8'd0, vel_gain};
      REG_ANGLE_OFFSET:    prdata = {16'd0, angle_offset};
      REG_POLE_PAIR_COUNT: prdata = {24'd0, pole_pair_count};
      default:             prdata = '0;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_ERR;
      ST_ERR:  state_next = ST_MULP;
      ST_MULP: state_next = ST_MULV;
      ST_MULV: state_next = ST_SPD;
      ST_SPD:  state_next = ST_PRED;
      ST_PRED: state_next = ST_MULE;
      ST_MULE: state_next = ST_OUT;
      ST_OUT:  if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign off_turn = 32'(angle_offset[ANGLE_BITS-1:0]) << TURN_SHIFT;

  always_comb begin
    s_tready = 1'b0;
    mul_en   = 1'b0;
    out_load = 1'b0;
    mul_a    = '0;
    mul_b    = BW'(pole_pair_count);
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_MULP: begin
        mul_en = 1'b1;
        mul_a  = err;
        mul_b  = BW'(pos_gain);
      end
      ST_MULV: begin
        mul_en = 1'b1;
        mul_a  = err;
        mul_b  = BW'(vel_gain);
      end
      ST_SPD: begin
        mul_en = 1'b1;
        mul_a  = AW'(angle_est + off_turn);
      end
      ST_MULE: begin
        mul_en = 1'b1;
        mul_a  = AW'(pred + off_turn);
      end
      ST_OUT: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  ato_mul #(
    .AW(AW),
    .BW(BW)
  ) u_mul (
    .clk(clk),
    .en (mul_en),
    .a  (mul_a),
    .b  (mul_b),
    .p  (prod)
  );

  // Datapath.
  assign diff    = enc - angle_est;
  assign pc_full = (prod + P_HALF) >>> GAIN_FRAC_BITS;
  assign vc_full = (prod + V_HALF) >>> VSH;
  assign spd_sum = PW'(speed_est) + vc_full;

  always_comb begin
    if (spd_sum > SPD_MAX) begin
      spd_sat = 32'sh7fff_ffff;
    end else if (spd_sum < SPD_MIN) begin
      spd_sat = -32'sh7fff_ffff - 32'sd1;
    end else begin
      spd_sat = 32'(spd_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      enc <= 32'(s_tdata[ANGLE_BITS-1:0]) << TURN_SHIFT;
    end
    if (state == ST_ERR) begin
      err <= (diff == 32'h8000_0000) ? {1'b0, diff} : {diff[31], diff};
    end
    if (state == ST_PRED) begin
      pred <= angle_est + speed_turn(speed_est);
      elec <= 16'(prod[31:TURN_SHIFT]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_est <= '0;
      speed_est <= '0;
    end else begin
      if (state == ST_MULV) begin
        angle_est <= angle_est + speed_turn(speed_est) + 32'(pc_full);
      end
      if (state == ST_SPD) begin
        speed_est <= spd_sat;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {16'(prod[31:TURN_SHIFT]), 16'(pred[31:TURN_SHIFT]), elec,
                  speed_est, 16'(angle_est[31:TURN_SHIFT])};
    end
  end

  // Checks.
  a_speed_only_in_update: assert property (@(posedge clk) disable iff (rst)
    (state != ST_SPD) |=> (speed_est == $past(speed_est)))
    else $error("speed estimate changed outside its update step");

  a_angle_only_in_update: assert property (@(posedge clk) disable iff (rst)
    (state != ST_MULV) |=> (angle_est == $past(angle_est)))
    else $error("angle estimate changed outside its update step");

  a_result_from_last_step: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_OUT))
    else $error("result transaction raised outside the output step");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_ERR))
    else $error("accepted transaction did not start the sequence");

endmodule
